// ===== hdl/lspd_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan packet decoder package
// Shared constants, codes, command and status types for the scan packet decoder.
// ----------------------------------------------------------------------------
package lspd_pkg;

  localparam int MAX_SAMPLES_DEF  = 64;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [7:0] MAGIC_FIRST  = 8'hAA;
  localparam logic [7:0] MAGIC_SECOND = 8'h55;

  localparam int NUM_W   = 44;
  localparam int DEN_W   = 30;
  localparam int QUO_W   = 26;
  localparam int ROT_W   = 27;
  localparam int ANG_W   = 28;
  localparam int SPAN_W  = 25;
  localparam int DIST_W  = 16;
  localparam int SIDX_W  = 6;
  localparam int CANG_W  = 15;
  localparam int SHIFT_W = 5;
  localparam int ATAN_W  = 22;

  localparam logic signed [ANG_W-1:0] DEG360    = 28'sd23592960;
  localparam logic signed [ROT_W-1:0] ROT_ONE   = 27'sd65536;
  localparam logic signed [21:0]      BASE_QMM  = 22'sd6212;
  localparam logic [7:0]              TRI_GAIN  = 8'd218;
  localparam logic [13:0]             DEN_SCALE = 14'd15530;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_MAGIC = 2'd1,
    ERR_COUNT = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    TGT_FIRST  = 2'd0,
    TGT_LAST   = 2'd1,
    TGT_SAMPLE = 2'd2
  } target_t;

  typedef struct packed {
    logic    ld_type;
    logic    ld_count;
    logic    ld_sa_lo;
    logic    ld_sa_hi;
    logic    ld_ea_lo;
    logic    ld_ea_hi;
    logic    ld_low;
    logic    wr_dist;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd;
    target_t rd_sel;
    logic    corr_div_start;
    logic    cord_init;
    logic    cord_step;
    logic    corr_latch;
    logic    take_first;
    logic    take_last;
    logic    span_take;
    logic    step_start;
    logic    sum_load;
    logic    red_step;
    logic    emit_sample;
    logic    emit_err;
    err_t    err_code;
  } cmd_t;

  typedef struct packed {
    logic byte_aa;
    logic byte_55;
    logic count_over;
    logic count_zero;
    logic phase;
    logic idx_last;
    logic div_busy;
    logic cord_last;
    logic red_ok;
    logic out_valid;
  } status_t;

  function automatic logic [ATAN_W-1:0] atan_entry(input logic [SHIFT_W-1:0] k);
    logic [ATAN_W-1:0] v;
    case (k)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lidar_scan_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// Triangulation lidar scan packet decoder
// Decodes scan packets and emits one corrected angle and distance per sample.
// ----------------------------------------------------------------------------
// Header and distance bytes are taken one per clock while in_stall is low. After
// the byte that completes the last distance, the block holds in_stall high while
// it computes the results: two corrections for the first and last samples, then
// one result per sample. Each correction runs a quotient through the shared
// bit-serial divider and then the CORDIC steps; each sample result needs its own
// correction plus a step quotient from the same divider and any 360-degree wrap
// steps. An item is also held off while a result waits on out_stall.
module lidar_scan_packet_decoder #(
  parameter int MAX_SAMPLES  = lspd_pkg::MAX_SAMPLES_DEF,
  parameter int CORDIC_STEPS = lspd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    stream_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lspd_pkg::SIDX_W-1:0]   sample_index,
  output logic [lspd_pkg::CANG_W-1:0]   corrected_angle,
  output logic [lspd_pkg::DIST_W-1:0]   distance_qmm,
  output logic                          zero_packet,
  output logic [1:0]                    error_code,
  output logic                          last_of_packet
);

  lspd_pkg::cmd_t    cmd;
  lspd_pkg::status_t sts;

  lspd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lspd_dp #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .stream_byte     (stream_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .sample_index    (sample_index),
    .corrected_angle (corrected_angle),
    .distance_qmm    (distance_qmm),
    .zero_packet     (zero_packet),
    .error_code      (error_code),
    .last_of_packet  (last_of_packet)
  );

endmodule

// ===== hdl/lspd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lspd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lspd_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lspd_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 30,
  parameter int QUO_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_reg;
  logic [NUM_W-1:0] numsh;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, numsh[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      den_reg <= den;
      numsh   <= num;
      quot    <= '0;
    end else if (busy) begin
      rem   <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
      numsh <= {numsh[NUM_W-2:0], 1'b0};
      quot  <= {quot[QUO_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/lspd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scan packet decoder controller
// Parses the byte stream and sequences the per-sample angle computation.
// ----------------------------------------------------------------------------
module lspd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lspd_pkg::status_t sts,
  output lspd_pkg::cmd_t    cmd
);

  typedef enum logic [21:0] {
    S_HUNT      = 22'd1 << 0,
    S_MAGIC     = 22'd1 << 1,
    S_TYPE      = 22'd1 << 2,
    S_COUNT     = 22'd1 << 3,
    S_SA_LO     = 22'd1 << 4,
    S_SA_HI     = 22'd1 << 5,
    S_EA_LO     = 22'd1 << 6,
    S_EA_HI     = 22'd1 << 7,
    S_CHK_A     = 22'd1 << 8,
    S_CHK_B     = 22'd1 << 9,
    S_DATA      = 22'd1 << 10,
    C_READ      = 22'd1 << 11,
    C_DIV_CORR  = 22'd1 << 12,
    C_WAIT_CORR = 22'd1 << 13,
    C_CORD_INIT = 22'd1 << 14,
    C_CORD      = 22'd1 << 15,
    C_CORR      = 22'd1 << 16,
    C_APPLY     = 22'd1 << 17,
    C_SPAN      = 22'd1 << 18,
    C_WAIT_STEP = 22'd1 << 19,
    C_SUM       = 22'd1 << 20,
    C_WRAP      = 22'd1 << 21
  } state_t;

  state_t              state, state_next;
  lspd_pkg::target_t   target, target_next;
  logic                rx;
  logic                accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = !rx || sts.out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_HUNT;
      target <= lspd_pkg::TGT_FIRST;
    end else begin
      state  <= state_next;
      target <= target_next;
    end
  end

  always_comb begin
    state_next  = state;
    target_next = target;
    rx          = 1'b0;
    cmd         = '0;
    cmd.rd_sel  = target;
    cmd.err_code = lspd_pkg::ERR_NONE;
    case (state)
      S_HUNT: begin
        rx = 1'b1;
        if (accept && sts.byte_aa) begin
          state_next = S_MAGIC;
        end
      end
      S_MAGIC: begin
        rx = 1'b1;
        if (accept) begin
          if (sts.byte_55) begin
            state_next = S_TYPE;
          end else begin
            cmd.emit_err = 1'b1;
            cmd.err_code = lspd_pkg::ERR_MAGIC;
            state_next   = sts.byte_aa ? S_MAGIC : S_HUNT;
          end
        end
      end
      S_TYPE: begin
        rx = 1'b1;
        if (accept) begin
          cmd.ld_type = 1'b1;
          state_next  = S_COUNT;
        end
      end
      S_COUNT: begin
        rx = 1'b1;
        if (accept) begin
          cmd.ld_count = 1'b1;
          if (sts.count_over) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = lspd_pkg::ERR_COUNT;
            state_next   = S_HUNT;
          end else begin
            state_next = S_SA_LO;
          end
        end
      end
      S_SA_LO: begin
        rx = 1'b1;
        if (accept) begin
          cmd.ld_sa_lo = 1'b1;
          state_next   = S_SA_HI;
        end
      end
      S_SA_HI: begin
        rx = 1'b1;
        if (accept) begin
          cmd.ld_sa_hi = 1'b1;
          state_next   = S_EA_LO;
        end
      end
      S_EA_LO: begin
        rx = 1'b1;
        if (accept) begin
          cmd.ld_ea_lo = 1'b1;
          state_next   = S_EA_HI;
        end
      end
      S_EA_HI: begin
        rx = 1'b1;
        if (accept) begin
          cmd.ld_ea_hi = 1'b1;
          state_next   = S_CHK_A;
        end
      end
      S_CHK_A: begin
        rx = 1'b1;
        if (accept) begin
          state_next = S_CHK_B;
        end
      end
      S_CHK_B: begin
        rx = 1'b1;
        if (accept) begin
          cmd.idx_clr = 1'b1;
          state_next  = sts.count_zero ? S_HUNT : S_DATA;
        end
      end
      S_DATA: begin
        rx = 1'b1;
        if (accept) begin
          if (!sts.phase) begin
            cmd.ld_low = 1'b1;
          end else begin
            cmd.wr_dist = 1'b1;
            if (sts.idx_last) begin
              target_next = lspd_pkg::TGT_FIRST;
              state_next  = C_READ;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
        end
      end
      C_READ: begin
        cmd.rd     = 1'b1;
        state_next = C_DIV_CORR;
      end
      C_DIV_CORR: begin
        cmd.corr_div_start = 1'b1;
        state_next         = C_WAIT_CORR;
      end
      C_WAIT_CORR: begin
        if (!sts.div_busy) begin
          state_next = C_CORD_INIT;
        end
      end
      C_CORD_INIT: begin
        cmd.cord_init = 1'b1;
        state_next    = C_CORD;
      end
      C_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_last) begin
          state_next = C_CORR;
        end
      end
      C_CORR: begin
        cmd.corr_latch = 1'b1;
        state_next     = C_APPLY;
      end
      C_APPLY: begin
        case (target)
          lspd_pkg::TGT_FIRST: begin
            cmd.take_first = 1'b1;
            target_next    = lspd_pkg::TGT_LAST;
            state_next     = C_READ;
          end
          lspd_pkg::TGT_LAST: begin
            cmd.take_last = 1'b1;
            state_next    = C_SPAN;
          end
          lspd_pkg::TGT_SAMPLE: begin
            cmd.step_start = 1'b1;
            state_next     = C_WAIT_STEP;
          end
          default: begin
            state_next = S_HUNT;
          end
        endcase
      end
      C_SPAN: begin
        if (sts.red_ok) begin
          cmd.span_take = 1'b1;
          cmd.idx_clr   = 1'b1;
          target_next   = lspd_pkg::TGT_SAMPLE;
          state_next    = C_READ;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      C_WAIT_STEP: begin
        if (!sts.div_busy) begin
          state_next = C_SUM;
        end
      end
      C_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = C_WRAP;
      end
      C_WRAP: begin
        if (!sts.red_ok) begin
          cmd.red_step = 1'b1;
        end else if (!sts.out_valid) begin
          cmd.emit_sample = 1'b1;
          if (sts.idx_last) begin
            state_next = S_HUNT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = C_READ;
          end
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sample || cmd.emit_err) |-> !sts.out_valid)
    else $error("result emitted over a pending result");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.corr_div_start || cmd.step_start) |-> !sts.div_busy)
    else $error("divider started while busy");

  a_no_rx_compute: assert property (@(posedge clk) disable iff (rst)
    (cmd.cord_step || cmd.sum_load) |-> in_stall)
    else $error("byte accepted during sample computation");

endmodule

// ===== hdl/lspd_dp.sv =====
// ----------------------------------------------------------------------------
// Scan packet decoder datapath
// Header registers, distance store, divider for corrections and angle steps, CORDIC, angle wrap.
// ----------------------------------------------------------------------------
module lspd_dp #(
  parameter int MAX_SAMPLES  = lspd_pkg::MAX_SAMPLES_DEF,
  parameter int CORDIC_STEPS = lspd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [7:0]                            stream_byte,
  input  lspd_pkg::cmd_t                        cmd,
  output lspd_pkg::status_t                     sts,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [lspd_pkg::SIDX_W-1:0]           sample_index,
  output logic [lspd_pkg::CANG_W-1:0]           corrected_angle,
  output logic [lspd_pkg::DIST_W-1:0]           distance_qmm,
  output logic                                  zero_packet,
  output logic [1:0]                            error_code,
  output logic                                  last_of_packet
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int KW = $clog2(CORDIC_STEPS);
  localparam int NUM_W = lspd_pkg::NUM_W;
  localparam int DEN_W = lspd_pkg::DEN_W;
  localparam int QUO_W = lspd_pkg::QUO_W;
  localparam int ROT_W = lspd_pkg::ROT_W;
  localparam int ANG_W = lspd_pkg::ANG_W;

  logic [7:0]                      ptype;
  logic [7:0]                      count;
  logic [15:0]                     start_raw;
  logic [15:0]                     end_raw;
  logic [7:0]                      low_hold;
  logic                            phase;
  logic [AW-1:0]                   idx;
  logic [AW-1:0]                   last_addr;
  logic [AW-1:0]                   raddr;
  logic [lspd_pkg::DIST_W-1:0]     rd_data;
  logic [lspd_pkg::DIST_W-1:0]     q_reg;
  logic                            neg_reg;
  logic signed [ROT_W-1:0]         x, y, z;
  logic signed [ROT_W-1:0]         xs, ys, at;
  logic [KW-1:0]                   k;
  logic signed [ROT_W-1:0]         corr;
  logic signed [ANG_W-1:0]         fsa;
  logic signed [ANG_W-1:0]         fsa_raw;
  logic signed [ANG_W-1:0]         lsa_raw;
  logic signed [ANG_W-1:0]         lsa;
  logic [lspd_pkg::SPAN_W-1:0]     span;
  logic signed [ANG_W-1:0]         red;
  logic                            red_ok;
  logic [19:0]                     q_ten;
  logic signed [21:0]              t_val;
  logic [19:0]                     t_mag;
  logic [27:0]                     num_mag;
  logic [NUM_W-1:0]                div_num;
  logic [DEN_W-1:0]                div_den;
  logic                            div_start;
  logic                            div_busy;
  logic [QUO_W-1:0]                quot;

  assign last_addr = AW'(count - 8'd1);

  always_comb begin
    case (cmd.rd_sel)
      lspd_pkg::TGT_FIRST:  raddr = '0;
      lspd_pkg::TGT_LAST:   raddr = last_addr;
      lspd_pkg::TGT_SAMPLE: raddr = idx;
      default:              raddr = '0;
    endcase
  end

  lspd_ram #(
    .WIDTH (lspd_pkg::DIST_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_dist),
    .waddr (idx),
    .wdata ({stream_byte, low_hold}),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign q_ten   = 20'({rd_data, 3'b000}) + 20'({rd_data, 1'b0});
  assign t_val   = lspd_pkg::BASE_QMM - $signed({2'b00, q_ten});
  assign t_mag   = t_val[21] ? 20'(-t_val) : t_val[19:0];
  assign num_mag = 28'(lspd_pkg::TRI_GAIN * t_mag);

  always_comb begin
    div_start = cmd.corr_div_start || cmd.step_start;
    if (cmd.corr_div_start) begin
      div_num = {num_mag, 16'h0000};
      div_den = DEN_W'(lspd_pkg::DEN_SCALE * rd_data);
    end else begin
      div_num = NUM_W'(span * idx);
      div_den = (count == 8'd1) ? DEN_W'(1) : DEN_W'(count - 8'd1);
    end
  end

  lspd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign xs = x >>> k;
  assign ys = y >>> k;
  assign at = $signed(ROT_W'(lspd_pkg::atan_entry(lspd_pkg::SHIFT_W'(k))));

  assign fsa_raw = $signed(ANG_W'({start_raw[15:1], 10'b0})) + ANG_W'(corr);
  assign lsa_raw = $signed(ANG_W'({end_raw[15:1], 10'b0})) + ANG_W'(corr);
  assign lsa     = lsa_raw[ANG_W-1] ? lsa_raw + lspd_pkg::DEG360 : lsa_raw;
  assign red_ok  = !red[ANG_W-1] && (red < lspd_pkg::DEG360);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      idx   <= '0;
      count <= '0;
    end else begin
      if (cmd.ld_count) begin
        count <= stream_byte;
      end
      if (cmd.idx_clr) begin
        idx   <= '0;
        phase <= 1'b0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + 1'b1;
        end
        if (cmd.ld_low) begin
          phase <= 1'b1;
        end else if (cmd.wr_dist) begin
          phase <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_type) begin
      ptype <= stream_byte;
    end
    if (cmd.ld_sa_lo) begin
      start_raw[7:0] <= stream_byte;
    end
    if (cmd.ld_sa_hi) begin
      start_raw[15:8] <= stream_byte;
    end
    if (cmd.ld_ea_lo) begin
      end_raw[7:0] <= stream_byte;
    end
    if (cmd.ld_ea_hi) begin
      end_raw[15:8] <= stream_byte;
    end
    if (cmd.ld_low) begin
      low_hold <= stream_byte;
    end
    if (cmd.corr_div_start) begin
      q_reg   <= rd_data;
      neg_reg <= t_val[21];
    end
    if (cmd.cord_init) begin
      x <= lspd_pkg::ROT_ONE;
      y <= $signed(ROT_W'(quot));
      z <= '0;
      k <= '0;
    end else if (cmd.cord_step) begin
      k <= k + 1'b1;
      if (!y[ROT_W-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
    end
    if (cmd.corr_latch) begin
      corr <= (q_reg == '0) ? '0 : (neg_reg ? -z : z);
    end
    if (cmd.take_first) begin
      fsa <= fsa_raw[ANG_W-1] ? fsa_raw + lspd_pkg::DEG360 : fsa_raw;
    end
    if (cmd.take_last) begin
      red <= lsa - fsa;
    end else if (cmd.sum_load) begin
      red <= fsa + $signed(ANG_W'(quot)) + ANG_W'(corr);
    end else if (cmd.red_step) begin
      red <= red[ANG_W-1] ? red + lspd_pkg::DEG360 : red - lspd_pkg::DEG360;
    end
    if (cmd.span_take) begin
      span <= red[lspd_pkg::SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sample || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      sample_index    <= '0;
      corrected_angle <= '0;
      distance_qmm    <= '0;
      zero_packet     <= 1'b0;
      error_code      <= cmd.err_code;
      last_of_packet  <= 1'b1;
    end else if (cmd.emit_sample) begin
      sample_index    <= lspd_pkg::SIDX_W'(idx);
      corrected_angle <= red[lspd_pkg::CANG_W+9:10];
      distance_qmm    <= q_reg;
      zero_packet     <= (ptype == 8'd1);
      error_code      <= lspd_pkg::ERR_NONE;
      last_of_packet  <= sts.idx_last;
    end
  end

  always_comb begin
    sts.byte_aa    = (stream_byte == lspd_pkg::MAGIC_FIRST);
    sts.byte_55    = (stream_byte == lspd_pkg::MAGIC_SECOND);
    sts.count_over = (stream_byte > 8'(MAX_SAMPLES));
    sts.count_zero = (count == 8'd0);
    sts.phase      = phase;
    sts.idx_last   = (idx == last_addr);
    sts.div_busy   = div_busy;
    sts.cord_last  = (k == KW'(CORDIC_STEPS - 1));
    sts.red_ok     = red_ok;
    sts.out_valid  = out_valid;
  end

  a_emit_wrapped: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_sample |-> red_ok)
    else $error("sample angle emitted before wrap finished");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_dist |-> (8'(idx) < count))
    else $error("distance written past sample count");

  a_cordic_idle_div: assert property (@(posedge clk) disable iff (rst)
    cmd.cord_init |-> !div_busy)
    else $error("CORDIC loaded before quotient ready");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Scan packet decoder testbench
// Drives scan byte streams with magic errors, count overflow, empty, single
// and full packets under random idling, and checks every result against a
// cycle-free model of the decoder kept in a small scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSAMP = lspd_pkg::MAX_SAMPLES_DEF;
  localparam int NSTEP = lspd_pkg::CORDIC_STEPS_DEF;
  localparam longint FULL_TURN = 64'd23592960;
  localparam int LIMIT = 3000000;

  typedef struct {
    logic [5:0]  sidx;
    logic [14:0] ang;
    logic [15:0] dqmm;
    logic        zp;
    logic [1:0]  err;
    logic        last;
  } scan_result_t;

  class scan_scoreboard;
    scan_result_t pending[$];
    int hpos, bcnt;
    logic [7:0] ptype, pcount, lowb;
    logic [15:0] sa_raw, ea_raw;
    logic [15:0] dists[NSAMP];
    int errors, results, bytes_in;

    function new();
      hpos = 0; bcnt = 0; ptype = 0; pcount = 0; lowb = 0;
      sa_raw = 0; ea_raw = 0; errors = 0; results = 0; bytes_in = 0;
      foreach (dists[i]) dists[i] = 0;
    endfunction

    function longint floor_shift(longint v, int k);
      if (v >= 0) return v >>> k;
      return -(((-v) - 1) >>> k) - 1;
    endfunction

    function longint wrap_turn(longint a);
      longint r;
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      return r;
    endfunction

    function longint atan_step(int k);
      longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
      return tbl[k];
    endfunction

    function longint tri_correction(logic [15:0] q);
      longint num, den, mag, x, y, z, xo;
      bit neg;
      if (q == 0) return 0;
      num = 218 * (6212 - 10 * longint'(q));
      den = 15530 * longint'(q);
      neg = num < 0;
      mag = ((neg ? -num : num) * 65536) / den;
      x = 65536; y = mag; z = 0;
      for (int k = 0; k < NSTEP && k < 24; k++) begin
        xo = x;
        if (y >= 0) begin
          x += floor_shift(y, k); y -= floor_shift(xo, k); z += atan_step(k);
        end else begin
          x -= floor_shift(y, k); y += floor_shift(xo, k); z -= atan_step(k);
        end
      end
      return neg ? -z : z;
    endfunction

    function void push(int sidx, longint ang, int dqmm, bit zp, lspd_pkg::err_t err,
                       bit last);
      scan_result_t r;
      r.sidx = 6'(sidx); r.ang = 15'(ang); r.dqmm = 16'(dqmm);
      r.zp = zp; r.err = err; r.last = last;
      pending.push_back(r);
    endfunction

    function void emit_samples();
      int n;
      longint fsa, lsa, span, st, a;
      n = pcount;
      fsa = longint'(sa_raw >> 1) * 1024 + tri_correction(dists[0]);
      lsa = longint'(ea_raw >> 1) * 1024 + tri_correction(dists[n-1]);
      if (fsa < 0) fsa += FULL_TURN;
      if (lsa < 0) lsa += FULL_TURN;
      span = wrap_turn(lsa - fsa);
      for (int i = 0; i < n; i++) begin
        st = (n > 1) ? (span * i) / (n - 1) : 0;
        a = wrap_turn(fsa + st + tri_correction(dists[i]));
        push(i, a / 1024, int'(dists[i]), ptype == 1, lspd_pkg::ERR_NONE, i == n - 1);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      bytes_in++;
      case (hpos)
        0: if (b == lspd_pkg::MAGIC_FIRST) hpos = 1;
        1: begin
          if (b == lspd_pkg::MAGIC_SECOND) hpos = 2;
          else begin
            hpos = (b == lspd_pkg::MAGIC_FIRST) ? 1 : 0;
            push(0, 0, 0, 1'b0, lspd_pkg::ERR_MAGIC, 1'b1);
          end
        end
        2: begin ptype = b; hpos = 3; end
        3: begin
          pcount = b;
          if (b > NSAMP) begin
            hpos = 0;
            push(0, 0, 0, 1'b0, lspd_pkg::ERR_COUNT, 1'b1);
          end else hpos = 4;
        end
        4: begin sa_raw[7:0] = b; hpos = 5; end
        5: begin sa_raw[15:8] = b; hpos = 6; end
        6: begin ea_raw[7:0] = b; hpos = 7; end
        7: begin ea_raw[15:8] = b; hpos = 8; end
        8: hpos = 9;
        9: begin bcnt = 0; hpos = (pcount == 0) ? 0 : 10; end
        default: begin
          if (bcnt % 2 == 0) begin
            lowb = b; bcnt++;
          end else begin
            dists[bcnt / 2] = {b, lowb};
            bcnt++;
            if (bcnt >= 2 * pcount) begin
              hpos = 0; bcnt = 0;
              emit_samples();
            end
          end
        end
      endcase
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t e;
      results++;
      if (pending.size() == 0) begin
        $error("unexpected result: index %0d angle %0d", got.sidx, got.ang);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.sidx !== e.sidx) begin
        $error("sample_index: expected %0d, got %0d", e.sidx, got.sidx); errors++;
      end
      if (got.ang !== e.ang) begin
        $error("corrected_angle: expected %0d, got %0d", e.ang, got.ang); errors++;
      end
      if (got.dqmm !== e.dqmm) begin
        $error("distance_qmm: expected %0d, got %0d", e.dqmm, got.dqmm); errors++;
      end
      if (got.zp !== e.zp) begin
        $error("zero_packet: expected %0d, got %0d", e.zp, got.zp); errors++;
      end
      if (got.err !== e.err) begin
        $error("error_code: expected %0d, got %0d", e.err, got.err); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_of_packet: expected %0d, got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [7:0] stream_byte;
  logic [5:0] sample_index;
  logic [14:0] corrected_angle;
  logic [15:0] distance_qmm;
  logic zero_packet, last_of_packet;
  logic [1:0] error_code;

  lidar_scan_packet_decoder u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stream_byte(stream_byte), .out_valid(out_valid), .out_stall(out_stall),
    .sample_index(sample_index), .corrected_angle(corrected_angle),
    .distance_qmm(distance_qmm), .zero_packet(zero_packet),
    .error_code(error_code), .last_of_packet(last_of_packet)
  );

  scan_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int cycles;
  logic [7:0] bytes_q[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst = 1; in_valid = 0; stream_byte = 0; out_stall = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        scan_result_t r;
        r.sidx = sample_index; r.ang = corrected_angle; r.dqmm = distance_qmm;
        r.zp = zero_packet; r.err = error_code; r.last = last_of_packet;
        sb.check_result(r);
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic queue_packet(logic [7:0] ptype, int n, logic [15:0] sa, logic [15:0] ea,
                              bit big_dist);
    logic [15:0] d;
    bytes_q.push_back(lspd_pkg::MAGIC_FIRST); bytes_q.push_back(lspd_pkg::MAGIC_SECOND);
    bytes_q.push_back(ptype); bytes_q.push_back(8'(n));
    bytes_q.push_back(sa[7:0]); bytes_q.push_back(sa[15:8]);
    bytes_q.push_back(ea[7:0]); bytes_q.push_back(ea[15:8]);
    bytes_q.push_back(8'($urandom)); bytes_q.push_back(8'($urandom));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: d = 16'd0;
        1: d = 16'hffff;
        2: d = 16'($urandom_range(1, 2000));
        default: d = big_dist ? 16'($urandom) : 16'($urandom_range(0, 8000));
      endcase
      bytes_q.push_back(d[7:0]); bytes_q.push_back(d[15:8]);
    end
  endtask

  task automatic flush_bytes();
    while (bytes_q.size() > 0) send_byte(bytes_q.pop_front());
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_burst(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 75)
        queue_packet($urandom_range(3) == 0 ? 8'd1 : 8'($urandom),
                     int'($urandom_range(5) == 0 ? $urandom_range(1, 64)
                                                 : $urandom_range(1, 8)),
                     16'($urandom), 16'($urandom), 1'($urandom_range(1)));
      else if (r < 82) begin
        bytes_q.push_back(lspd_pkg::MAGIC_FIRST); bytes_q.push_back(8'($urandom));
      end else if (r < 88) begin
        bytes_q.push_back(lspd_pkg::MAGIC_FIRST); bytes_q.push_back(lspd_pkg::MAGIC_SECOND);
        bytes_q.push_back(8'($urandom)); bytes_q.push_back(8'($urandom_range(65, 255)));
      end else if (r < 92) queue_packet(8'($urandom), 0, 16'($urandom), 16'($urandom), 1'b0);
      else repeat ($urandom_range(1, 6)) bytes_q.push_back(8'($urandom));
      flush_bytes();
    end
  endtask

  initial begin
    wait (rst === 0);
    @(posedge clk);
    bytes_q.push_back(8'h00); bytes_q.push_back(8'hff); bytes_q.push_back(8'h55);
    bytes_q.push_back(lspd_pkg::MAGIC_FIRST); bytes_q.push_back(8'h12);
    bytes_q.push_back(lspd_pkg::MAGIC_FIRST); bytes_q.push_back(lspd_pkg::MAGIC_FIRST);
    bytes_q.push_back(lspd_pkg::MAGIC_SECOND); bytes_q.push_back(8'd1);
    bytes_q.push_back(8'd65);
    bytes_q.push_back(lspd_pkg::MAGIC_FIRST); bytes_q.push_back(lspd_pkg::MAGIC_SECOND);
    bytes_q.push_back(8'hff); bytes_q.push_back(8'hff);
    flush_bytes();
    queue_packet(8'd1, 0, 16'h0000, 16'hffff, 1'b0);
    queue_packet(8'd0, 1, 16'hffff, 16'h0000, 1'b1);
    queue_packet(8'd1, 2, 16'hfff0, 16'h0010, 1'b0);
    flush_bytes();

    queue_packet(8'd0, 64, 16'h1234, 16'h5678, 1'b1);
    fork
      flush_bytes();
      begin
        hold_off = 1;
        repeat (8000) @(posedge clk);
        hold_off = 0;
      end
    join

    random_burst(4);
    send_idle_pct = 64; random_burst(3);
    send_idle_pct = 0; recv_stall_pct = 64; random_burst(3);
    send_idle_pct = 22; recv_stall_pct = 22; random_burst(3);
    send_idle_pct = 0; recv_stall_pct = 0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (8000) @(posedge clk);
    $display("Sent %0d stream bytes and checked %0d results across four idling phases.",
             sb.bytes_in, sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
